/* rtl/core/rssi_presence_tracker_macros.svh */
// Assertion macros shared by the presence tracker RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef RSSI_PRESENCE_TRACKER_MACROS_SVH
`define RSSI_PRESENCE_TRACKER_MACROS_SVH

// Clocked implication or plain property, disabled while in reset.
`define RPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define RPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* rtl/core/rpt_pkg.sv */
// Package of the presence tracker: payload structs, codes and reset values.
// Used by the top module, the sequencer and the event monitor; depends on nothing.
`timescale 1ns / 1ps

package rpt_pkg;

  // Operation codes of an input item.
  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Event kinds of a result item.
  localparam logic [1:0] KIND_DETECT     = 2'd0;
  localparam logic [1:0] KIND_ABSENT     = 2'd1;
  localparam logic [1:0] KIND_SWEEP_DONE = 2'd2;

  // Configuration port and register indexes.
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_ACQ_THR       = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DET_THR       = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_DETECT_DELAY  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_ABSENT_DELAY  = 8'd3;

  // Register values after reset.
  localparam logic signed [7:0] ACQ_THR_RST      = -8'sd70;
  localparam logic signed [7:0] DET_THR_RST      = -8'sd60;
  localparam logic [15:0]       DETECT_DELAY_RST = 16'd15;
  localparam logic [15:0]       ABSENT_DELAY_RST = 16'd30;

  // At most this many ABSENT events in one sweep.
  localparam int                AbsCntW    = 6;
  localparam logic [AbsCntW-1:0] MAX_ABSENT = 6'd32;

  typedef struct packed {
    logic              operation;
    logic [15:0]       tag_id;
    logic signed [7:0] rssi;
    logic [31:0]       now_sec;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] event_tag;
    logic [31:0] event_time;
    logic        last;
  } result_t;

  // One word of the entry memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] first_seen;
    logic [31:0] absent_since;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_e;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic rd_en;
    logic proc_valid;
    logic finish;
  } seq_ctrl_t;

endpackage

/* rtl/core/rssi_presence_tracker.sv */
// Presence tracker of neighbour tags from beacon signal strength.
// Every item but a beacon with tag zero walks the whole table, one entry per cycle through the
// single read port of the entry memory: busy stays high from the accepting edge until the walk
// and its finishing step are done, and no new item is accepted while busy is high. A beacon
// with tag zero is accepted, does nothing and leaves busy low. Results leave as one-cycle
// strobes on res_strobe_o and cannot be held off: a beacon gives at most one DETECT with last
// set in the first cycle with busy low again, and a sweep gives its ABSENT events during the
// walk and then the sweep finished marker with last set in that same cycle. No clearing pass
// after reset is needed. Configuration writes are always taken and must only be made while
// idle.
// Depends on rpt_pkg, rpt_seq, rpt_elapsed, rpt_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "rssi_presence_tracker_macros.svh"

module rssi_presence_tracker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rpt_pkg::item_t                  item_i,
  output logic                            res_strobe_o,
  output rpt_pkg::result_t                res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rpt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rpt_pkg::CfgDataW-1:0]    cfg_data_i
);

  import rpt_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration registers.
  logic signed [7:0] acq_thr_q, det_thr_q;
  logic [15:0]       detect_delay_q, absent_delay_q;

  // Latched item, per-entry flags and search results.
  item_t                  item_q;
  logic [TABLE_DEPTH-1:0] occ_q, occ_d;
  logic [TABLE_DEPTH-1:0] det_q, det_d;
  logic [TABLE_DEPTH-1:0] seen_q, seen_d;
  logic                   found_v_q, found_v_d;
  logic [AddrW-1:0]       found_idx_q, found_idx_d;
  logic [31:0]            found_fs_q, found_fs_d;
  logic                   free_v_q, free_v_d;
  logic [AddrW-1:0]       free_idx_q, free_idx_d;
  logic [AbsCntW-1:0]     abs_cnt_q, abs_cnt_d;

  // Result register.
  logic    res_strobe_q, res_strobe_d;
  result_t res_q, res_d;

  // Sequencer, memory and shared unit connections.
  logic             accept, go;
  seq_ctrl_t        ctrl;
  logic [AddrW-1:0] rd_addr, proc_idx;
  entry_t           rd_data, wdata;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      el_base, eff_fa;
  logic [15:0]      el_delay;
  logic             reached;
  logic signed [7:0] thr;
  logic             pass;

  assign accept      = start && !busy;
  assign go          = accept && !((item_i.operation == OP_BEACON) && (item_i.tag_id == 16'd0));
  assign cfg_ready_o = 1'b1;

  rpt_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .busy_o    (busy),
    .rd_addr_o (rd_addr),
    .proc_idx_o(proc_idx),
    .ctrl_o    (ctrl)
  );

  rpt_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // A zero first absent time means unset; the sweep then starts it now.
  assign eff_fa = (rd_data.absent_since == 32'd0) ? item_q.now_sec : rd_data.absent_since;

  // The elapsed unit serves the DETECT check at the finish and the ABSENT check in the walk.
  assign el_base  = ctrl.finish ? found_fs_q : eff_fa;
  assign el_delay = ctrl.finish ? detect_delay_q : absent_delay_q;

  rpt_elapsed u_elapsed (
    .now_i    (item_q.now_sec),
    .base_i   (el_base),
    .delay_i  (el_delay),
    .reached_o(reached)
  );

  // Detected tags need the stricter threshold, which gives hysteresis.
  assign thr  = (found_v_q && det_q[found_idx_q]) ? det_thr_q : acq_thr_q;
  assign pass = $signed(item_q.rssi) > $signed(thr);

  // Table update, memory write and result selection.
  always_comb begin
    occ_d        = occ_q;
    det_d        = det_q;
    seen_d       = seen_q;
    found_v_d    = found_v_q;
    found_idx_d  = found_idx_q;
    found_fs_d   = found_fs_q;
    free_v_d     = free_v_q;
    free_idx_d   = free_idx_q;
    abs_cnt_d    = abs_cnt_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = proc_idx;
    wdata        = rd_data;

    if (accept) begin
      found_v_d = 1'b0;
      free_v_d  = 1'b0;
      abs_cnt_d = '0;
    end

    if (ctrl.proc_valid) begin
      if (item_q.operation == OP_BEACON) begin
        // First matching entry and first free entry.
        if (!found_v_q && occ_q[proc_idx] && (rd_data.tag == item_q.tag_id)) begin
          found_v_d   = 1'b1;
          found_idx_d = proc_idx;
          found_fs_d  = rd_data.first_seen;
        end
        if (!free_v_q && !occ_q[proc_idx]) begin
          free_v_d   = 1'b1;
          free_idx_d = proc_idx;
        end
      end else if (occ_q[proc_idx]) begin
        if (seen_q[proc_idx]) begin
          // Seen since the last sweep: restart the absence watch.
          seen_d[proc_idx]   = 1'b0;
          we                 = 1'b1;
          wdata.absent_since = 32'd0;
        end else if (!det_q[proc_idx]) begin
          occ_d[proc_idx] = 1'b0;
        end else if (reached && (abs_cnt_q < MAX_ABSENT)) begin
          occ_d[proc_idx]  = 1'b0;
          det_d[proc_idx]  = 1'b0;
          abs_cnt_d        = abs_cnt_q + 1'b1;
          res_strobe_d     = 1'b1;
          res_d.event_kind = KIND_ABSENT;
          res_d.event_tag  = rd_data.tag;
          res_d.event_time = eff_fa;
          res_d.last       = 1'b0;
        end else begin
          we                 = 1'b1;
          wdata.absent_since = eff_fa;
        end
      end
    end

    if (ctrl.finish) begin
      if (item_q.operation == OP_SWEEP) begin
        res_strobe_d     = 1'b1;
        res_d.event_kind = KIND_SWEEP_DONE;
        res_d.event_tag  = 16'd0;
        res_d.event_time = 32'd0;
        res_d.last       = 1'b1;
      end else if (pass) begin
        if (found_v_q) begin
          seen_d[found_idx_q] = 1'b1;
          if (reached && !det_q[found_idx_q]) begin
            det_d[found_idx_q] = 1'b1;
            res_strobe_d       = 1'b1;
            res_d.event_kind   = KIND_DETECT;
            res_d.event_tag    = item_q.tag_id;
            res_d.event_time   = found_fs_q;
            res_d.last         = 1'b1;
          end
        end else if (free_v_q) begin
          // New tag takes the lowest free entry.
          we                 = 1'b1;
          waddr              = free_idx_q;
          wdata.tag          = item_q.tag_id;
          wdata.first_seen   = item_q.now_sec;
          wdata.absent_since = 32'd0;
          occ_d[free_idx_q]  = 1'b1;
          det_d[free_idx_q]  = 1'b0;
          seen_d[free_idx_q] = 1'b1;
        end
      end
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_thr_q      <= ACQ_THR_RST;
      det_thr_q      <= DET_THR_RST;
      detect_delay_q <= DETECT_DELAY_RST;
      absent_delay_q <= ABSENT_DELAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ACQ_THR:      acq_thr_q      <= $signed(cfg_data_i[7:0]);
        CFG_DET_THR:      det_thr_q      <= $signed(cfg_data_i[7:0]);
        CFG_DETECT_DELAY: detect_delay_q <= cfg_data_i;
        CFG_ABSENT_DELAY: absent_delay_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q        <= '0;
      det_q        <= '0;
      seen_q       <= '0;
      found_v_q    <= 1'b0;
      free_v_q     <= 1'b0;
      abs_cnt_q    <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      occ_q        <= occ_d;
      det_q        <= det_d;
      seen_q       <= seen_d;
      found_v_q    <= found_v_d;
      free_v_q     <= free_v_d;
      abs_cnt_q    <= abs_cnt_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    found_idx_q <= found_idx_d;
    found_fs_q  <= found_fs_d;
    free_idx_q  <= free_idx_d;
    res_q       <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // A sweep transfer always starts the table walk.
  `RPT_ASSERT(a_sweep_starts, (accept && (item_i.operation == OP_SWEEP)) |=> busy, "no walk")
  // The final result of an item is never directly followed by another result.
  `RPT_ASSERT(a_last_alone, (res_strobe_o && res_o.last) |=> !res_strobe_o, "result after last")
  // Detected and seen flags only stand on occupied entries.
  `RPT_ASSERT_NEVER(a_flags_occ, ((det_q | seen_q) & ~occ_q) != '0, "flag on free entry")

endmodule

/* rtl/core/rpt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module rpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rpt_elapsed.sv */
// Shared elapsed-time unit: checks whether a wrapping time difference has
// reached a delay. Depends on nothing.
`timescale 1ns / 1ps

module rpt_elapsed (
  input  logic [31:0] now_i,
  input  logic [31:0] base_i,
  input  logic [15:0] delay_i,
  output logic        reached_o
);

  logic [31:0] diff;

  // The difference wraps modulo 2^32, as the time counter does.
  assign diff      = now_i - base_i;
  assign reached_o = (diff >= {16'd0, delay_i});

endmodule

/* rtl/core/rpt_seq.sv */
// Sequencer of the presence tracker: walks the entry memory one address per
// cycle and marks the processing and finishing cycles. Uses rpt_pkg.
`timescale 1ns / 1ps

module rpt_seq #(
  parameter int TABLE_DEPTH = 32,
  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  output logic                  busy_o,
  output logic [AddrW-1:0]      rd_addr_o,
  output logic [AddrW-1:0]      proc_idx_o,
  output rpt_pkg::seq_ctrl_t    ctrl_o
);

  import rpt_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_DEPTH - 1);

  state_e           state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             proc_valid_q;
  logic [AddrW-1:0] proc_idx_q;
  logic             rd_en;
  logic             finish;

  // Next state and walk address.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_SCAN;
          addr_d  = '0;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == LastAddr) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    rd_en  = 1'b0;
    finish = 1'b0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE:   busy_o = 1'b0;
      ST_SCAN:   rd_en  = 1'b1;
      ST_LAST:   rd_en  = 1'b0;
      ST_FINISH: finish = 1'b1;
      default:   busy_o = 1'b0;
    endcase
  end

  // Strobes packed in the order of the control struct.
  assign ctrl_o     = {rd_en, proc_valid_q, finish};
  assign rd_addr_o  = addr_q;
  assign proc_idx_o = proc_idx_q;

  // State registers; read data is valid in the cycle after the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      addr_q       <= '0;
      proc_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      proc_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= addr_q;
  end

endmodule

/* sim/rpt_event_monitor.sv */
// Event monitor of the presence tracker: watches the item, configuration and result transfers,
// predicts the events of every accepted item and compares them in order of arrival.
// Depends on rpt_pkg for the payload structs, event kinds and register indexes.
`timescale 1ns / 1ps

module rpt_event_monitor
  import rpt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  item_t               item_i,
  input  logic                res_strobe_i,
  input  result_t             res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int MaxAbsentPerSweep = 32;
  localparam int ReportLimit       = 10;

  // Predicted copy of the tag table and of the registers.
  logic [15:0]       tag_tbl          [TABLE_DEPTH];
  logic              detected_tbl     [TABLE_DEPTH];
  logic              seen_tbl         [TABLE_DEPTH];
  logic [31:0]       first_seen_tbl   [TABLE_DEPTH];
  logic [31:0]       absent_since_tbl [TABLE_DEPTH];
  logic signed [7:0] acq_thr;
  logic signed [7:0] det_thr;
  logic [15:0]       detect_delay;
  logic [15:0]       absent_delay;

  // Events still owed by the block, oldest first.
  result_t expected_events [$];
  int      mismatches;

  function automatic result_t make_event(logic [1:0] kind, logic [15:0] tag, logic [31:0] stamp,
                                         logic last);
    result_t ev;
    ev.event_kind = kind;
    ev.event_tag  = tag;
    ev.event_time = stamp;
    ev.last       = last;
    return ev;
  endfunction

  task automatic clear_entry(int idx);
    tag_tbl[idx]          = '0;
    detected_tbl[idx]     = 1'b0;
    seen_tbl[idx]         = 1'b0;
    first_seen_tbl[idx]   = '0;
    absent_since_tbl[idx] = '0;
  endtask

  // A counted beacon refreshes its tag or claims the lowest free entry.
  task automatic predict_beacon(item_t it);
    int                found;
    int                free_idx;
    logic signed [7:0] level;
    logic signed [7:0] thr;
    logic [31:0]       age;
    found    = -1;
    free_idx = -1;
    if (it.tag_id == '0) return;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (found < 0 && tag_tbl[i] == it.tag_id) found = i;
      if (free_idx < 0 && tag_tbl[i] == '0) free_idx = i;
    end
    level = it.rssi;
    thr   = (found >= 0 && detected_tbl[found]) ? det_thr : acq_thr;
    if (level <= thr) return;
    if (found >= 0) begin
      age = it.now_sec - first_seen_tbl[found];
      seen_tbl[found] = 1'b1;
      if (age >= {16'h0, detect_delay} && !detected_tbl[found]) begin
        detected_tbl[found] = 1'b1;
        expected_events.push_back(make_event(KIND_DETECT, it.tag_id, first_seen_tbl[found],
                                             1'b1));
      end
    end else if (free_idx >= 0) begin
      tag_tbl[free_idx]          = it.tag_id;
      detected_tbl[free_idx]     = 1'b0;
      seen_tbl[free_idx]         = 1'b1;
      first_seen_tbl[free_idx]   = it.now_sec;
      absent_since_tbl[free_idx] = '0;
    end
  endtask

  // The sweep ages every occupied entry and always ends with the finished marker.
  task automatic predict_sweep(logic [31:0] now_sec);
    int absents;
    absents = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tag_tbl[i] == '0) continue;
      if (seen_tbl[i]) begin
        seen_tbl[i]         = 1'b0;
        absent_since_tbl[i] = '0;
      end else if (!detected_tbl[i]) begin
        clear_entry(i);
      end else begin
        // A first absence at time zero reads as unset and is taken again next sweep.
        if (absent_since_tbl[i] == '0) absent_since_tbl[i] = now_sec;
        if (now_sec - absent_since_tbl[i] >= {16'h0, absent_delay} &&
            absents < MaxAbsentPerSweep) begin
          expected_events.push_back(make_event(KIND_ABSENT, tag_tbl[i], absent_since_tbl[i],
                                               1'b0));
          absents++;
          clear_entry(i);
        end
      end
    end
    expected_events.push_back(make_event(KIND_SWEEP_DONE, '0, '0, 1'b1));
  endtask

  task automatic check_event(result_t got);
    result_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: unexpected event kind=%0d tag=%h time=%h last=%b", $realtime,
                 got.event_kind, got.event_tag, got.event_time, got.last);
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind || got.event_tag !== want.event_tag ||
        got.event_time !== want.event_time || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: event mismatch, expected kind=%0d tag=%h time=%h last=%b", $realtime,
                 want.event_kind, want.event_tag, want.event_time, want.last);
        $display("  got kind=%0d tag=%h time=%h last=%b", got.event_kind, got.event_tag,
                 got.event_time, got.last);
      end
    end
  endtask

  // Results are checked before a new item is predicted, as a strobe at the accepting edge
  // still belongs to the previous item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) clear_entry(i);
      acq_thr      = ACQ_THR_RST;
      det_thr      = DET_THR_RST;
      detect_delay = DETECT_DELAY_RST;
      absent_delay = ABSENT_DELAY_RST;
      expected_events.delete();
      mismatches   = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_strobe_i) check_event(res_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ACQ_THR:      acq_thr = cfg_data_i[7:0];
          CFG_DET_THR:      det_thr = cfg_data_i[7:0];
          CFG_DETECT_DELAY: detect_delay = cfg_data_i;
          CFG_ABSENT_DELAY: absent_delay = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (item_i.operation == OP_SWEEP) predict_sweep(item_i.now_sec);
        else predict_beacon(item_i);
      end
      mismatches_o <= mismatches;
      pending_o    <= expected_events.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Top of the presence tracker testbench: clock, reset, item and configuration stimulus,
// and the verdict. Depends on rpt_pkg, rssi_presence_tracker and rpt_event_monitor.
`timescale 1ns / 1ps

module tb_top;
  import rpt_pkg::*;

  localparam int TableDepth  = 32;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_UNUSED = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_LAST_UNUSED  = 8'hFF;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item;
  logic                res_strobe;
  result_t             res;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int          mismatches;
  int          pending;
  int          idle_pct;
  int          phase_items;
  int          cycle_count = 0;
  logic [31:0] now_sec;

  rssi_presence_tracker #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .res_strobe_o(res_strobe),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rpt_event_monitor #(
    .TABLE_DEPTH(TableDepth)
  ) u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .res_strobe_i(res_strobe),
    .res_i       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one item after a random idle spell and returns at the edge of its transfer.
  task automatic send(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic beacon(logic [15:0] tag, logic signed [7:0] level, logic [31:0] stamp);
    item_t it;
    it.operation = OP_BEACON;
    it.tag_id    = tag;
    it.rssi      = level;
    it.now_sec   = stamp;
    send(it);
  endtask

  // The tag and level of a sweep are don't-care, so they carry random bits.
  task automatic sweep(logic [31:0] stamp);
    item_t it;
    it.operation = OP_SWEEP;
    it.tag_id    = 16'($urandom());
    it.rssi      = 8'($urandom());
    it.now_sec   = stamp;
    send(it);
  endtask

  // Holds the sender off until every predicted event has arrived and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Writes all four registers while idle, plus one index outside the register map.
  // Threshold writes carry random upper bits, which the block must ignore.
  task automatic configure(logic signed [7:0] acq, logic signed [7:0] det,
                           logic [15:0] det_delay, logic [15:0] abs_delay);
    settle();
    cfg_write(CFG_ACQ_THR, {8'($urandom()), acq});
    cfg_write(CFG_DET_THR, {8'($urandom()), det});
    cfg_write(CFG_DETECT_DELAY, det_delay);
    cfg_write(CFG_ABSENT_DELAY, abs_delay);
    cfg_write(CfgIdxW'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // One listening cycle: a few beacons from a small tag pool, mostly strong, then a sweep.
  task automatic listening_round(int pool, int max_step);
    int                beacons;
    int                r;
    logic [15:0]       tag;
    logic signed [7:0] level;
    beacons = $urandom_range(1, 8);
    repeat (beacons) begin
      r = $urandom_range(99);
      if (r < 4) tag = '0;
      else if (r < 10) tag = 16'($urandom());
      else tag = 16'($urandom_range(1, pool));
      if ($urandom_range(99) < 75) level = 8'($urandom_range(0, 127));
      else level = 8'($urandom());
      now_sec += 32'($urandom_range(0, max_step));
      if ($urandom_range(99) < 3) now_sec += $urandom();
      beacon(tag, level, now_sec);
      phase_items++;
    end
    now_sec += 32'($urandom_range(0, max_step));
    sweep(now_sec);
    phase_items++;
  endtask

  initial begin
    idle_pct    = 0;
    phase_items = 0;
    now_sec     = '0;
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset register values.
    beacon(16'h0000, 8'sd127, 32'd100);         // tag zero is ignored
    beacon(16'hFFFF, -8'sd70, 32'd100);         // level equal to threshold does not count
    beacon(16'hFFFF, -8'sd69, 32'd100);         // new entry
    beacon(16'h0001, 8'sd127, 32'd100);
    beacon(16'hFFFF, -8'sd69, 32'd114);         // one second short of detection
    beacon(16'hFFFF, -8'sd69, 32'd115);         // detection
    beacon(16'hFFFF, -8'sd60, 32'd116);         // detected tag needs the stricter threshold
    beacon(16'h0001, -8'sd128, 32'd116);
    sweep(32'd120);                             // both seen: flags cleared
    sweep(32'd121);                             // undetected tag freed, absence starts
    sweep(32'd151);                             // absence delay reached exactly
    beacon(16'h0002, 8'sd0, 32'hFFFF_FFF8);
    beacon(16'h0002, 8'sd0, 32'h0000_0007);     // age wraps past zero
    sweep(32'h0000_0007);
    sweep(32'h0000_0000);                       // absence at time zero stays unset
    sweep(32'h0000_0010);
    sweep(32'h0000_002E);

    // Wide hysteresis, short delays.
    configure(-8'sd90, -8'sd50, 16'd3, 16'd5);
    phase_items = 0;
    while (phase_items < 20) listening_round(10, 3);

    // Lowest acquire level, detected tags never refreshed, zero delays; fill the table.
    configure(-8'sd128, 8'sd127, 16'd0, 16'd0);
    idle_pct = 81;
    for (int k = 0; k < TableDepth + 2; k++) begin
      now_sec += 32'($urandom_range(0, 2));
      beacon(16'h8000 | 16'(k), 8'sd100, now_sec);
    end
    phase_items = 0;
    while (phase_items < 10) listening_round(40, 2);

    // Longest delays with large steps in time.
    configure(-8'sd1, -8'sd128, 16'hFFFF, 16'hFFFF);
    idle_pct = 12;
    phase_items = 0;
    while (phase_items < 20) listening_round(12, 40000);

    // Highest thresholds: nothing counts, the table drains.
    configure(8'sd127, 8'sd127, 16'd1, 16'd1);
    idle_pct = 0;
    phase_items = 0;
    while (phase_items < 8) listening_round(12, 4);

    // Random moderate settings with stretches of idling and full drains after the later rounds.
    configure(8'($urandom_range(156, 236)), 8'($urandom_range(176, 255)),
              16'($urandom_range(0, 20)), 16'($urandom_range(0, 40)));
    phase_items = 0;
    while (phase_items < 20) begin
      idle_pct = ($urandom_range(1) != 0) ? 81 : 0;
      listening_round(8, 8);
      if (phase_items >= 12 && phase_items < 20) settle();
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
